// ===== rtl/core/bflr_pkg.sv =====
// shared constants for the buffer free list ring: pool size, field widths and status codes
// no dependencies
package bflr_pkg;

  localparam int unsigned POOL_ENTRIES = 1024;

  localparam int unsigned PTR_W    = $clog2(POOL_ENTRIES);
  localparam int unsigned CNT_W    = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned HANDLE_W = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FCOUNT_W = 11;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  localparam logic REQ_GET    = 1'b0;
  localparam logic REQ_RETURN = 1'b1;

endpackage

// ===== rtl/core/bflr_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module bflr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/buffer_free_list_ring_unit.sv =====
// Buffer free list ring: one get or return request per beat, one result beat per request.
// The ring of free handles sits in a 1024 x 10 ram; the entry at the read pointer is
// prefetched every cycle, so a request is taken each cycle while the result register
// is free or being drained. Entries not yet written since reset read as their own
// index via a fill count, so there is no clearing pass after reset.
// depends on bflr_pkg and bflr_ram
module buffer_free_list_ring_unit
  import bflr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // free_handle[9:0], zero pad
  input  logic                  s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // handle[9:0], status[11:10],
                                                // free_count[22:12], pool_empty[23],
                                                // pool_full[24], zero pad
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(POOL_ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(POOL_ENTRIES);

  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic                fwd_hit_q, fwd_hit_d;
  logic [HANDLE_W-1:0] fwd_data_q;
  logic                out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic                accept;
  logic                is_get;
  logic                empty_now;
  logic                full_now;
  logic                do_get;
  logic                we;
  logic [HANDLE_W-1:0] ram_rdata;
  logic [HANDLE_W-1:0] head_handle;
  logic [HANDLE_W-1:0] handle;
  logic [STATUS_W-1:0] status;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_get        = (s_axis_tuser == REQ_GET);
  assign empty_now     = (cnt_q == '0);
  assign full_now      = (cnt_q == CNT_FULL);
  assign do_get        = accept && is_get && !empty_now;
  assign we            = accept && !is_get && !full_now;

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    cnt_d    = cnt_q;
    fill_d   = fill_q;
    if (do_get) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      cnt_d    = cnt_q - 1'b1;
    end
    if (we) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      cnt_d    = cnt_q + 1'b1;
      if (fill_q != CNT_FULL) begin
        fill_d = fill_q + 1'b1;
      end
    end
  end

  assign fwd_hit_d = we && (wr_ptr_q == rd_ptr_d);

  bflr_ram #(
    .WIDTH(HANDLE_W),
    .DEPTH(POOL_ENTRIES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_ptr_q),
    .wdata_i (s_axis_tdata[HANDLE_W-1:0]),
    .raddr_i (rd_ptr_d),
    .rdata_o (ram_rdata)
  );

  // head entry: just-written value, ram contents, or reset image (own index)
  always_comb begin
    if (fwd_hit_q) begin
      head_handle = fwd_data_q;
    end else if (CNT_W'(rd_ptr_q) < fill_q) begin
      head_handle = ram_rdata;
    end else begin
      head_handle = HANDLE_W'(rd_ptr_q);
    end
  end

  always_comb begin
    handle = '0;
    status = STATUS_OK;
    if (is_get) begin
      if (empty_now) begin
        status = STATUS_EMPTY;
      end else begin
        handle = head_handle;
      end
    end else if (full_now) begin
      status = STATUS_FULL;
    end
  end

  assign out_valid_d = accept || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      cnt_q       <= CNT_FULL;
      fill_q      <= '0;
      fwd_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      fwd_hit_q   <= fwd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= s_axis_tdata[HANDLE_W-1:0];
    if (accept) begin
      out_data_q <= {7'd0,
                     (cnt_d == CNT_FULL),
                     (cnt_d == '0),
                     FCOUNT_W'(cnt_d),
                     status,
                     handle};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== bench/tb_buffer_free_list_ring_unit.sv =====
// self-checking bench for buffer_free_list_ring_unit: directed and random get and return beats
// with an in-bench free list predictor, checked field by field under random idling
// depends on bflr_pkg and the unit's rtl
module tb_buffer_free_list_ring_unit;
  import bflr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] free_handle;
  } pool_req_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
    logic [FCOUNT_W-1:0] free_count;
    logic                pool_empty;
    logic                pool_full;
  } pool_result_t;

  typedef enum {GEN_MIXED, GEN_DRAIN, GEN_REFILL} gen_mode_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  logic [HANDLE_W-1:0] free_ring [POOL_ENTRIES];
  logic [PTR_W-1:0]    ring_rd_ptr;
  logic [PTR_W-1:0]    ring_wr_ptr;
  logic [FCOUNT_W-1:0] ring_free_cnt;

  pool_req_t    planned_reqs[$];
  pool_req_t    pending_reqs[$];
  pool_result_t expected_results[$];
  int unsigned  planned_free;
  int unsigned  src_idle_pct  = 0;
  int unsigned  snk_stall_pct = 0;
  int unsigned  error_count   = 0;

  buffer_free_list_ring_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic pool_result_t predict_pool_step(logic req_type,
                                                     logic [HANDLE_W-1:0] give);
    pool_result_t r = '0;
    r.status = STATUS_OK;
    if (req_type == REQ_GET) begin
      if (ring_free_cnt == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        r.handle      = free_ring[ring_rd_ptr];
        ring_rd_ptr   = (ring_rd_ptr == PTR_W'(POOL_ENTRIES - 1)) ? '0 : ring_rd_ptr + 1'b1;
        ring_free_cnt = ring_free_cnt - 1'b1;
      end
    end else begin
      if (ring_free_cnt >= POOL_ENTRIES) begin
        r.status = STATUS_FULL;
      end else begin
        free_ring[ring_wr_ptr] = give;
        ring_wr_ptr   = (ring_wr_ptr == PTR_W'(POOL_ENTRIES - 1)) ? '0 : ring_wr_ptr + 1'b1;
        ring_free_cnt = ring_free_cnt + 1'b1;
      end
    end
    r.free_count = ring_free_cnt;
    r.pool_empty = (ring_free_cnt == 0);
    r.pool_full  = (ring_free_cnt >= POOL_ENTRIES);
    return r;
  endfunction

  // tracks the free count while planning so the random walk can steer between empty and full
  task automatic plan_req(logic req_type, logic [HANDLE_W-1:0] h);
    planned_reqs.push_back('{req_type: req_type, free_handle: h});
    if (req_type == REQ_GET && planned_free > 0) begin
      planned_free--;
    end else if (req_type == REQ_RETURN && planned_free < POOL_ENTRIES) begin
      planned_free++;
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    pool_req_t next_req;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        next_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_req.req_type;
        s_axis_tdata  <= IN_DATA_W'(next_req.free_handle);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // monitor: predict on request beats, check on result beats
  always @(posedge clk_i) begin
    pool_result_t exp_r;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_pool_step(s_axis_tuser,
                                                   s_axis_tdata[HANDLE_W-1:0]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, actual %h",
                 $time, m_axis_tdata);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("handle",     exp_r.handle,     m_axis_tdata[9:0]);
        check_field("status",     exp_r.status,     m_axis_tdata[11:10]);
        check_field("free_count", exp_r.free_count, m_axis_tdata[22:12]);
        check_field("pool_empty", exp_r.pool_empty, m_axis_tdata[23]);
        check_field("pool_full",  exp_r.pool_full,  m_axis_tdata[24]);
      end
    end
  end

  initial begin
    int unsigned idle_plan [5][2] = '{'{0, 0}, '{0, 0}, '{45, 0}, '{0, 45}, '{29, 29}};
    int unsigned bounds [6];
    int unsigned n_dir;
    int unsigned n_rand;
    int unsigned rail_hits;
    int unsigned pct_get;
    gen_mode_e   gen_mode;
    logic        req;
    logic [HANDLE_W-1:0] h;

    for (int i = 0; i < POOL_ENTRIES; i++) begin
      free_ring[i] = HANDLE_W'(i);
    end
    ring_rd_ptr   = '0;
    ring_wr_ptr   = '0;
    ring_free_cnt = FCOUNT_W'(POOL_ENTRIES);
    planned_free  = POOL_ENTRIES;

    // directed: returns on a full pool, first grants, foreign and duplicate handles
    plan_req(REQ_RETURN, 10'd5);
    plan_req(REQ_RETURN, 10'h3ff);
    plan_req(REQ_GET,    10'h3ff);
    plan_req(REQ_GET,    10'd0);
    plan_req(REQ_RETURN, 10'h3ff);
    plan_req(REQ_RETURN, 10'd0);
    plan_req(REQ_RETURN, 10'h2aa);
    plan_req(REQ_GET,    10'h155);
    plan_req(REQ_GET,    10'd0);
    plan_req(REQ_GET,    10'h3ff);
    plan_req(REQ_RETURN, 10'd3);
    plan_req(REQ_RETURN, 10'd3);
    plan_req(REQ_GET,    10'd0);
    plan_req(REQ_RETURN, 10'h155);
    plan_req(REQ_RETURN, 10'h200);
    plan_req(REQ_GET,    10'd0);
    plan_req(REQ_GET,    10'd0);
    plan_req(REQ_GET,    10'd0);
    plan_req(REQ_RETURN, 10'd1);
    plan_req(REQ_RETURN, 10'h3fe);
    n_dir = planned_reqs.size();

    // random walk: mixed near full, then drain to empty and start refilling
    n_rand    = 0;
    rail_hits = 0;
    gen_mode  = GEN_MIXED;
    while (n_rand < 1430) begin
      if (gen_mode == GEN_MIXED && n_rand >= 150) gen_mode = GEN_DRAIN;
      pct_get = (gen_mode == GEN_MIXED) ? 50 : (gen_mode == GEN_DRAIN) ? 96 : 4;
      req = ($urandom_range(99) < pct_get) ? REQ_GET : REQ_RETURN;
      case ($urandom_range(3))
        0: h = HANDLE_W'(1 << $urandom_range(HANDLE_W - 1));
        1: h = $urandom_range(1) ? '1 : '0;
        default: h = HANDLE_W'($urandom_range(1023));
      endcase
      plan_req(req, h);
      n_rand++;
      if (gen_mode == GEN_DRAIN && planned_free == 0) begin
        rail_hits++;
        if (rail_hits >= 5) begin
          gen_mode  = GEN_REFILL;
          rail_hits = 0;
        end
      end else if (gen_mode == GEN_REFILL && planned_free == POOL_ENTRIES) begin
        rail_hits++;
        if (rail_hits >= 5) begin
          gen_mode  = GEN_DRAIN;
          rail_hits = 0;
        end
      end
    end

    bounds[0] = 0;
    bounds[1] = n_dir;
    for (int k = 1; k <= 4; k++) begin
      bounds[k+1] = n_dir + (k * n_rand) / 4;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // each chunk waits for every result before the next starts
    for (int c = 0; c < 5; c++) begin
      @(negedge clk_i);
      src_idle_pct  = idle_plan[c][0];
      snk_stall_pct = idle_plan[c][1];
      for (int i = bounds[c]; i < bounds[c+1]; i++) begin
        pending_reqs.push_back(planned_reqs[i]);
      end
      while (pending_reqs.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
        @(negedge clk_i);
      end
    end

    repeat (8) @(negedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("buffer_free_list_ring_unit test passed");
    end else begin
      $display("buffer_free_list_ring_unit test failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("buffer_free_list_ring_unit test failed");
    $finish;
  end

endmodule
